/* src/ssb_pkg.sv */
// Package for the selection sort buffer: queue word type, back-end state type
// and fixed constants. No dependencies.
package ssb_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          final_item;
      logic                          keep;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_EMIT
   } back_state_type;

endpackage

/* src/ssb_front.sv */
// Front end of the selection sort buffer: accepts input words and marks each
// as kept or dropped against the run capacity. Depends on ssb_pkg.
module ssb_front #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic signed [ssb_pkg::VALUE_WIDTH-1:0] req_tdata,
   input  logic                                req_tlast,
   output logic                                push,
   output ssb_pkg::cmd_type                    push_data,
   input  logic                                q_full
);
   import ssb_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] run_cnt_ff, run_cnt_in;
   logic          keep;

   assign keep       = run_cnt_ff < CW'(CAPACITY);
   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      push_data.value      = req_tdata;
      push_data.final_item = req_tlast;
      push_data.keep       = keep;
   end

   always_comb begin
      run_cnt_in = run_cnt_ff;
      if (push) begin
         if (req_tlast) begin
            run_cnt_in = '0;
         end else if (keep) begin
            run_cnt_in = run_cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= '0;
      end else begin
         run_cnt_ff <= run_cnt_in;
      end
   end

endmodule

/* src/ssb_queue.sv */
// Two-entry queue that carries classified words from the front end to the
// back end. Depends on ssb_pkg.
module ssb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ssb_pkg::cmd_type push_data,
   output logic             q_full,
   output logic             q_vld,
   output ssb_pkg::cmd_type q_data,
   input  logic             q_pop
);
   import ssb_pkg::*;

   cmd_type    entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign q_full = cnt_ff == 2'(QUEUE_DEPTH);
   assign q_vld  = cnt_ff != 2'd0;
   assign q_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* src/ssb_back.sv */
// Back end of the selection sort buffer: value store, selection sort sequencer
// and result output register. Depends on ssb_pkg.
module ssb_back #(
   parameter int CAPACITY = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_vld,
   input  ssb_pkg::cmd_type                        q_data,
   output logic                                    q_pop,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic signed [ssb_pkg::VALUE_WIDTH-1:0]  rsp_tdata,
   output logic                                    rsp_tlast,
   output logic                                    rsp_tuser
);
   import ssb_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];

   back_state_type state_ff, state_in;
   logic [CW-1:0] n_ff, n_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic          rvld_ff, rvld_in;
   logic [CW-1:0] tag_ff, tag_in;
   logic signed [VALUE_WIDTH-1:0] rdata_ff;
   logic signed [VALUE_WIDTH-1:0] posval_ff, posval_in;
   logic signed [VALUE_WIDTH-1:0] best_ff, best_in;
   logic [CW-1:0] bidx_ff, bidx_in;
   logic          out_vld_ff, out_vld_in;
   logic signed [VALUE_WIDTH-1:0] out_data_ff, out_data_in;
   logic          out_last_ff, out_last_in;
   logic          out_drop_ff, out_drop_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;

   logic          out_ready;
   logic          last_tag;
   logic          pos_last;
   logic          do_swap;
   logic [CW-1:0] load_n;

   assign out_ready  = !out_vld_ff || rsp_tready;
   assign last_tag   = tag_ff == (n_ff - CW'(1));
   assign pos_last   = (pos_ff + CW'(2)) == n_ff;
   assign do_swap    = best_ff < posval_ff;
   assign load_n     = n_ff + CW'(q_data.keep);
   assign q_pop      = (state_ff == ST_LOAD) && q_vld;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_drop_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (q_pop && q_data.final_item) begin
               state_in = (load_n >= CW'(2)) ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (rvld_ff && last_tag) begin
               state_in = ST_SWAP_A;
            end
         end
         ST_SWAP_A: begin
            if (do_swap) begin
               state_in = ST_SWAP_B;
            end else begin
               state_in = pos_last ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SWAP_B: begin
            state_in = pos_last ? ST_EMIT : ST_SCAN;
         end
         ST_EMIT: begin
            if (rvld_ff && last_tag && out_ready) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      n_in        = n_ff;
      ovf_in      = ovf_ff;
      pos_in      = pos_ff;
      iss_in      = iss_ff;
      rvld_in     = 1'b0;
      tag_in      = tag_ff;
      posval_in   = posval_ff;
      best_in     = best_ff;
      bidx_in     = bidx_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      out_drop_in = out_drop_ff;
      rd_en       = 1'b0;
      rd_addr     = iss_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = n_ff[AW-1:0];
      wr_data     = q_data.value;
      case (state_ff)
         ST_LOAD: begin
            if (q_pop) begin
               wr_en  = q_data.keep;
               n_in   = load_n;
               ovf_in = ovf_ff || !q_data.keep;
               if (q_data.final_item) begin
                  pos_in = '0;
                  iss_in = '0;
               end
            end
         end
         ST_SCAN: begin
            rd_en = iss_ff < n_ff;
            if (rd_en) begin
               iss_in = iss_ff + CW'(1);
               tag_in = iss_ff;
            end
            rvld_in = rd_en;
            if (rvld_ff) begin
               if (tag_ff == pos_ff) begin
                  posval_in = rdata_ff;
               end else if (tag_ff == (pos_ff + CW'(1))) begin
                  best_in = rdata_ff;
                  bidx_in = tag_ff;
               end else if (rdata_ff < best_ff) begin
                  best_in = rdata_ff;
                  bidx_in = tag_ff;
               end
            end
         end
         ST_SWAP_A: begin
            if (do_swap) begin
               wr_en   = 1'b1;
               wr_addr = bidx_ff[AW-1:0];
               wr_data = posval_ff;
            end else begin
               pos_in = pos_ff + CW'(1);
               iss_in = pos_last ? '0 : (pos_ff + CW'(1));
            end
         end
         ST_SWAP_B: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_data = best_ff;
            pos_in  = pos_ff + CW'(1);
            iss_in  = pos_last ? '0 : (pos_ff + CW'(1));
         end
         ST_EMIT: begin
            rd_en = (iss_ff < n_ff) && (!rvld_ff || out_ready);
            if (rd_en) begin
               iss_in = iss_ff + CW'(1);
               tag_in = iss_ff;
            end
            if (rd_en) begin
               rvld_in = 1'b1;
            end else begin
               rvld_in = rvld_ff && !out_ready;
            end
            if (rvld_ff && out_ready) begin
               out_vld_in  = 1'b1;
               out_data_in = rdata_ff;
               out_last_in = last_tag;
               out_drop_in = ovf_ff;
               if (last_tag) begin
                  n_in   = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: begin
            rvld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      iss_ff      <= iss_in;
      tag_ff      <= tag_in;
      posval_ff   <= posval_in;
      best_ff     <= best_in;
      bidx_ff     <= bidx_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         n_ff       <= '0;
         ovf_ff     <= 1'b0;
         rvld_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         n_ff       <= n_in;
         ovf_ff     <= ovf_in;
         rvld_ff    <= rvld_in;
         out_vld_ff <= out_vld_in;
      end
   end

endmodule

/* src/selection_sort_buffer.sv */
// Top level of the selection sort buffer: front end, queue and back end.
// Depends on ssb_pkg, ssb_front, ssb_queue and ssb_back.
//
// Words of a run load at one per cycle when not held off into a store of
// CAPACITY entries; words beyond capacity are dropped and every result of that
// run then carries tuser = 1. The word with tlast = 1 ends the run: the store
// is then sorted ascending in place; its one read port scans one entry per
// cycle for each position, and the held values then follow as results at up
// to one per cycle, the last with tlast = 1. Input is held off during sort
// and output once the two-word queue behind the input fills.
module selection_sort_buffer #(
   parameter int CAPACITY = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // value[31:0]
   input  logic signed [ssb_pkg::VALUE_WIDTH-1:0]  req_tdata,
   input  logic                                    req_tlast,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // sorted_value[31:0]
   output logic signed [ssb_pkg::VALUE_WIDTH-1:0]  rsp_tdata,
   output logic                                    rsp_tlast,
   // dropped[0]
   output logic                                    rsp_tuser
);
   import ssb_pkg::*;

   logic    push;
   cmd_type push_data;
   logic    q_full;
   logic    q_vld;
   cmd_type q_data;
   logic    q_pop;

   ssb_front #(
      .CAPACITY(CAPACITY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   ssb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full),
      .q_vld     (q_vld),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   ssb_back #(
      .CAPACITY(CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_vld      (q_vld),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
